@@ rtl/dif_pkg.sv @@
// ----------------------------------------------------------------------------
// dif_pkg: shared types and constants of the decimal integer field formatter
// Holds field limits, ASCII codes, length mode codes, the queue descriptor
// and the status structs passed between the front, queue and back.
// ----------------------------------------------------------------------------
package dif_pkg;

  localparam int MAX_FIELD  = 64;
  localparam int MAG_W      = 64;
  localparam int NUM_DIGITS = 20;
  localparam int FW_W       = $clog2(MAX_FIELD + 1);
  localparam int PREC_W     = 6;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int BIT_CNT_W  = $clog2(MAG_W);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  // One classified conversion waiting for the back end.
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic              has_sign;
    logic [7:0]        sign_ch;
    logic              left;
    logic              zero;
    logic [FW_W-1:0]   width;
    logic [PREC_W-1:0] prec;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic idle;
    logic emitting;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIZE,
    BK_EMIT
  } back_state_t;

endpackage

@@ rtl/dif_front.sv @@
// ----------------------------------------------------------------------------
// dif_front: conversion classifier
// Cuts the raw value to its length mode, takes the magnitude, picks the sign
// character and clamps width and precision into one queue descriptor.
// ----------------------------------------------------------------------------
module dif_front (
  input  logic [63:0]  in_value_bits,
  input  logic         in_is_signed,
  input  logic [1:0]   in_length_mode,
  input  logic         in_left_justify,
  input  logic         in_force_plus,
  input  logic         in_space_sign,
  input  logic         in_zero_pad,
  input  logic [6:0]   in_field_width,
  input  logic         in_precision_given,
  input  logic [5:0]   in_min_digits,
  output dif_pkg::desc_t desc
);
  import dif_pkg::*;

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [15:0]      v16;
  logic [31:0]      v32;

  assign v16 = in_value_bits[15:0];
  assign v32 = in_value_bits[31:0];

  always_comb begin
    unique case (in_length_mode)
      LEN_SHORT: begin
        neg = in_is_signed & v16[15];
        mag = {48'd0, (neg ? (~v16 + 16'd1) : v16)};
      end
      LEN_LONG: begin
        neg = in_is_signed & in_value_bits[63];
        mag = neg ? (~in_value_bits + 64'd1) : in_value_bits;
      end
      default: begin
        neg = in_is_signed & v32[31];
        mag = {32'd0, (neg ? (~v32 + 32'd1) : v32)};
      end
    endcase
  end

  always_comb begin
    desc.mag      = mag;
    desc.has_sign = in_is_signed & (neg | in_force_plus | in_space_sign);
    desc.sign_ch  = neg ? CH_MINUS : (in_force_plus ? CH_PLUS : CH_SPACE);
    desc.left     = in_left_justify;
    desc.zero     = in_zero_pad;
    desc.width    = (in_field_width > 7'(MAX_FIELD)) ? FW_W'(MAX_FIELD)
                                                      : FW_W'(in_field_width);
    desc.prec     = in_precision_given ? PREC_W'(in_min_digits) : '0;
  end

endmodule

@@ rtl/dif_queue.sv @@
// ----------------------------------------------------------------------------
// dif_queue: descriptor queue
// A short FIFO between the front and the back so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module dif_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dif_pkg::desc_t     push_desc,
  input  logic               pop,
  output dif_pkg::desc_t     head_desc,
  output dif_pkg::q_status_t status
);
  import dif_pkg::*;

  desc_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_desc    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ rtl/dif_back.sv @@
// ----------------------------------------------------------------------------
// dif_back: digit converter and character sequencer
// Converts the magnitude to BCD one bit a cycle (shift and add three), sizes
// the field, then emits one character per cycle in field order.
// ----------------------------------------------------------------------------
module dif_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dif_pkg::desc_t      head_desc,
  input  dif_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  output logic [7:0]          out_char,
  output logic                out_last_char,
  output dif_pkg::bk_status_t status
);
  import dif_pkg::*;

  back_state_t state_r, state_nxt;

  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [3:0]           bcd_r [NUM_DIGITS];
  logic [3:0]           bcd_nxt [NUM_DIGITS];
  logic [3:0]           adj [NUM_DIGITS];
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  logic                 sign_pend_r, sign_pend_nxt;
  logic [7:0]           sign_ch_r, sign_ch_nxt;
  logic                 left_r, left_nxt;
  logic                 zero_r, zero_nxt;
  logic [FW_W-1:0]      width_r, width_nxt;
  logic [PREC_W-1:0]    prec_r, prec_nxt;

  logic [FW_W-1:0]      lead_r, lead_nxt;
  logic [FW_W-1:0]      zcnt_r, zcnt_nxt;
  logic [DIG_CNT_W-1:0] dig_r, dig_nxt;
  logic [FW_W-1:0]      trail_r, trail_nxt;
  logic [FW_W-1:0]      rem_r, rem_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 emit;
  logic [DIG_CNT_W-1:0] nd;
  logic [PREC_W-1:0]    total;
  logic [FW_W-1:0]      len;
  logic [FW_W-1:0]      pad;
  logic [DIG_CNT_W-1:0] dig_m1;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [7:0]           ch;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_status.empty) state_nxt = BK_CONV;
      BK_CONV: if (bit_cnt_r == '0) state_nxt = BK_SIZE;
      BK_SIZE: state_nxt = BK_EMIT;
      BK_EMIT: if (rem_r == FW_W'(1)) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop             = 1'b0;
    emit            = 1'b0;
    status.idle     = 1'b0;
    status.emitting = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop         = ~q_status.empty;
        status.idle = 1'b1;
      end
      BK_EMIT: begin
        emit            = 1'b1;
        status.emitting = 1'b1;
      end
      default: ;
    endcase
  end

  // Shift-and-add-three step: every digit at five or more gets three added.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  // Digit count: one past the highest nonzero digit, and never below one.
  always_comb begin
    nd = DIG_CNT_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) nd = DIG_CNT_W'(i + 1);
    end
    total = (PREC_W'(nd) > prec_r) ? PREC_W'(nd) : prec_r;
    len   = FW_W'(total) + FW_W'(sign_pend_r);
    pad   = (width_r > len) ? (width_r - len) : '0;
  end

  assign dig_m1  = dig_r - 1'b1;
  assign dig_idx = dig_m1[DIG_IDX_W-1:0];

  // Characters go out in field order: leading spaces, sign, zeros, digits,
  // trailing spaces.
  always_comb begin
    if (lead_r != '0) begin
      ch = CH_SPACE;
    end else if (sign_pend_r) begin
      ch = sign_ch_r;
    end else if (zcnt_r != '0) begin
      ch = CH_ZERO;
    end else if (dig_r != '0) begin
      ch = CH_ZERO | {4'd0, bcd_r[dig_idx]};
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    sign_pend_nxt = sign_pend_r;
    sign_ch_nxt   = sign_ch_r;
    left_nxt      = left_r;
    zero_nxt      = zero_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    lead_nxt      = lead_r;
    zcnt_nxt      = zcnt_r;
    dig_nxt       = dig_r;
    trail_nxt     = trail_r;
    rem_nxt       = rem_r;
    out_valid_nxt = emit;
    out_char_nxt  = ch;
    out_last_nxt  = emit & (rem_r == FW_W'(1));

    if (pop) begin
      mag_nxt       = head_desc.mag;
      for (int i = 0; i < NUM_DIGITS; i++) bcd_nxt[i] = 4'd0;
      bit_cnt_nxt   = BIT_CNT_W'(MAG_W - 1);
      sign_pend_nxt = head_desc.has_sign;
      sign_ch_nxt   = head_desc.sign_ch;
      left_nxt      = head_desc.left;
      zero_nxt      = head_desc.zero;
      width_nxt     = head_desc.width;
      prec_nxt      = head_desc.prec;
    end

    if (state_r == BK_CONV) begin
      bcd_nxt[0] = {adj[0][2:0], mag_r[MAG_W-1]};
      for (int i = 1; i < NUM_DIGITS; i++) begin
        bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
      end
      mag_nxt     = {mag_r[MAG_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - 1'b1;
    end

    if (state_r == BK_SIZE) begin
      lead_nxt  = (!left_r && !zero_r) ? pad : '0;
      zcnt_nxt  = ((!left_r && zero_r) ? pad : '0) + FW_W'(total - PREC_W'(nd));
      dig_nxt   = nd;
      trail_nxt = left_r ? pad : '0;
      rem_nxt   = pad + len;
    end

    if (emit) begin
      rem_nxt = rem_r - 1'b1;
      if (lead_r != '0) begin
        lead_nxt = lead_r - 1'b1;
      end else if (sign_pend_r) begin
        sign_pend_nxt = 1'b0;
      end else if (zcnt_r != '0) begin
        zcnt_nxt = zcnt_r - 1'b1;
      end else if (dig_r != '0) begin
        dig_nxt = dig_r - 1'b1;
      end else if (trail_r != '0) begin
        trail_nxt = trail_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    sign_pend_r <= sign_pend_nxt;
    sign_ch_r   <= sign_ch_nxt;
    left_r      <= left_nxt;
    zero_r      <= zero_nxt;
    width_r     <= width_nxt;
    prec_r      <= prec_nxt;
    lead_r      <= lead_nxt;
    zcnt_r      <= zcnt_nxt;
    dig_r       <= dig_nxt;
    trail_r     <= trail_nxt;
    out_char_r  <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

@@ rtl/decimal_integer_field_formatter.sv @@
// ----------------------------------------------------------------------------
// decimal_integer_field_formatter: printf %d / %i / %u field formatter
// Takes one integer conversion and streams its formatted field as ASCII
// characters, one beat per character, the final one marked.
// ----------------------------------------------------------------------------
// A conversion is taken when start is high and busy is low; up to two
// conversions wait in a queue while the back end works. The back end takes
// each conversion through a load step, bit-serial binary to BCD conversion
// of all 64 magnitude bits and a sizing step for the field, then emits one
// character per cycle; a field holds 1 to 64 characters.
// Characters leave on out_char with out_valid high for exactly one cycle
// each, back to back within a field, and out_last_char marks the final one.
// The receiver must take every beat as it comes.
module decimal_integer_field_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  input  logic        in_is_signed,
  input  logic [1:0]  in_length_mode,
  input  logic        in_left_justify,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_zero_pad,
  input  logic [6:0]  in_field_width,
  input  logic        in_precision_given,
  input  logic [5:0]  in_min_digits,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last_char
);
  import dif_pkg::*;

  desc_t      front_desc;
  desc_t      head_desc;
  q_status_t  q_status;
  bk_status_t bk_status;
  logic       accept;
  logic       pop;

  assign busy   = q_status.full;
  assign accept = start & ~busy;

  dif_front u_front (
    .in_value_bits      (in_value_bits),
    .in_is_signed       (in_is_signed),
    .in_length_mode     (in_length_mode),
    .in_left_justify    (in_left_justify),
    .in_force_plus      (in_force_plus),
    .in_space_sign      (in_space_sign),
    .in_zero_pad        (in_zero_pad),
    .in_field_width     (in_field_width),
    .in_precision_given (in_precision_given),
    .in_min_digits      (in_min_digits),
    .desc               (front_desc)
  );

  dif_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_desc (front_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .status    (q_status)
  );

  dif_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_desc     (head_desc),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .status        (bk_status)
  );

  // A last-character mark never stands without its beat.
  a_last_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_char |-> out_valid)
    else $error("last-character mark without a beat");

  // The field ends the emit phase, so no beat follows the last one at once.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |=> !out_valid)
    else $error("beat directly after the last character of a field");

  // An accepted conversion is in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !q_status.empty)
    else $error("accepted conversion missing from the queue");

  // Beats come out only while the back end is in its emit phase.
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(bk_status.emitting))
    else $error("beat outside the emit phase");

endmodule
